### rtl/core/npe_pkg.sv
`timescale 1ns / 1ps

package npe_pkg;

    localparam int MAX_TERMS = 16;
    localparam int FRAC_BITS = 16;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ENTRY_W   = 2 * DATA_W;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int TCNT_W    = 5;
    localparam int S_TDATA_W = 3 * DATA_W;
    localparam int M_TDATA_W = ((DATA_W + TCNT_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - DATA_W - TCNT_W;

    localparam logic signed [PROD_W-1:0] RND_HALF =
        (FRAC_BITS > 0) ? (PROD_W'(1) <<< ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0))
                        : PROD_W'(0);

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD0,
        ST_PREP,
        ST_MUL,
        ST_RND,
        ST_ADD,
        ST_FIN
    } npe_state_t;

endpackage

### rtl/core/npe_ram.sv
`timescale 1ns / 1ps

module npe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/nested_polynomial_eval.sv
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)                         tuser (low bit up)
// s_        in   base_point[31:0] coefficient[63:32]         req_type[0]
//                x_value[95:64]
// m_        out  poly_value[31:0] term_count[36:32] pad      overflow[0] rejected[1]
//
// Push or empty-table eval: ST_IDLE goes straight to ST_FIN, which registers the result.
// Eval over n > 1 terms: ST_LOAD0, ST_PREP, then ST_MUL, ST_RND and ST_ADD for each further
// term (the multiply, round and add recurrence on the accumulator), then ST_FIN (one term: ST_LOAD0, ST_FIN).
// Reset clears the term count, the sequencer and the result valid; table
// entries stay undefined until pushed.
// A new item is taken while an earlier result still waits on m_tready.
module nested_polynomial_eval import npe_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // base_point, coefficient, x_value
    input  logic [0:0]           s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // poly_value, term_count, zero pad
    output logic [1:0]           m_tuser    // overflow, rejected
);

    localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [CNT_W-1:0]  ONE   = CNT_W'(1);

    npe_state_t state_reg, state_next;

    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [DATA_W-1:0]        x_reg, x_next;
    logic [DATA_W-1:0]        acc_reg, acc_next;
    logic [DATA_W-1:0]        d_reg, d_next;
    logic [DATA_W-1:0]        coef_reg, coef_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0]        p_reg, p_next;
    logic                     ovf_reg, ovf_next;
    logic [DATA_W-1:0]        res_value_reg, res_value_next;
    logic                     res_rej_reg, res_rej_next;
    logic                     m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]        m_value_reg, m_value_next;
    logic [TCNT_W-1:0]        m_tcnt_reg, m_tcnt_next;
    logic                     m_ovf_reg, m_ovf_next;
    logic                     m_rej_reg, m_rej_next;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic [DATA_W-1:0]   rd_base, rd_coef;

    logic                s_acc, out_free;
    logic                req;
    logic [DATA_W-1:0]   in_base, in_coef, in_x;
    logic [CNT_W-1:0]    next_idx;
    logic                more;

    logic signed [DATA_W:0]   diff_w, sum_w;
    logic [DATA_W-1:0]        diff_sat, sum_sat, rnd_sat;
    logic                     diff_ovf, sum_ovf, rnd_ovf;
    logic signed [PROD_W-1:0] rnd_sum, rnd_sh;
    logic [CNT_W+TCNT_W-1:0]  cnt_ext;

    npe_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TERMS),
        .AW    (ADDR_W)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign req      = s_tuser[0];
    assign in_base  = s_tdata[DATA_W-1:0];
    assign in_coef  = s_tdata[2*DATA_W-1:DATA_W];
    assign in_x     = s_tdata[3*DATA_W-1:2*DATA_W];

    assign rd_base  = ram_rdata[DATA_W-1:0];
    assign rd_coef  = ram_rdata[ENTRY_W-1:DATA_W];
    assign next_idx = idx_reg + ONE;
    assign more     = (next_idx != n_reg);

    // datapath: difference, round/shift, coefficient add, each saturating
    always_comb begin
        diff_w   = $signed({x_reg[DATA_W-1], x_reg}) - $signed({rd_base[DATA_W-1], rd_base});
        diff_ovf = (diff_w[DATA_W] != diff_w[DATA_W-1]);
        diff_sat = diff_ovf ? (diff_w[DATA_W] ? S_MIN : S_MAX) : diff_w[DATA_W-1:0];

        prod_next = $signed(acc_reg) * $signed(d_reg);

        rnd_sum = prod_reg + RND_HALF;
        rnd_sh  = rnd_sum >>> FRAC_BITS;
        rnd_ovf = !((&rnd_sh[PROD_W-1:DATA_W-1]) || !(|rnd_sh[PROD_W-1:DATA_W-1]));
        rnd_sat = rnd_ovf ? (rnd_sh[PROD_W-1] ? S_MIN : S_MAX) : rnd_sh[DATA_W-1:0];

        sum_w   = $signed({p_reg[DATA_W-1], p_reg}) + $signed({coef_reg[DATA_W-1], coef_reg});
        sum_ovf = (sum_w[DATA_W] != sum_w[DATA_W-1]);
        sum_sat = sum_ovf ? (sum_w[DATA_W] ? S_MIN : S_MAX) : sum_w[DATA_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (req == REQ_EVAL && cnt_reg != '0) begin
                        state_next = ST_LOAD0;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_LOAD0: state_next = (n_reg == ONE) ? ST_FIN : ST_PREP;
            ST_PREP:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_RND;
            ST_RND:   state_next = ST_ADD;
            ST_ADD:   state_next = more ? ST_MUL : ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign cnt_ext = {TCNT_W'(0), cnt_reg};

    always_comb begin
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        d_next         = d_reg;
        coef_next      = coef_reg;
        p_next         = p_reg;
        ovf_next       = ovf_reg;
        res_value_next = res_value_reg;
        res_rej_next   = res_rej_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_value_next   = m_value_reg;
        m_tcnt_next    = m_tcnt_reg;
        m_ovf_next     = m_ovf_reg;
        m_rej_next     = m_rej_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[ADDR_W-1:0];
        ram_wdata      = {in_coef, in_base};
        ram_re         = 1'b0;
        ram_raddr      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    res_value_next = '0;
                    ovf_next       = 1'b0;
                    res_rej_next   = 1'b0;
                    if (req == REQ_PUSH) begin
                        if (cnt_reg < CNT_W'(MAX_TERMS)) begin
                            ram_we   = 1'b1;
                            cnt_next = cnt_reg + ONE;
                        end else begin
                            res_rej_next = 1'b1;
                        end
                    end else begin
                        n_next = cnt_reg;
                        x_next = in_x;
                        if (cnt_reg != '0) begin
                            ram_re = 1'b1;
                        end
                    end
                end
            end
            ST_LOAD0: begin
                acc_next       = rd_coef;
                res_value_next = rd_coef;
                if (n_reg != ONE) begin
                    ram_re    = 1'b1;
                    ram_raddr = ONE[ADDR_W-1:0];
                    idx_next  = ONE;
                end
            end
            ST_PREP: begin
                d_next    = diff_sat;
                coef_next = rd_coef;
                ovf_next  = ovf_reg | diff_ovf;
            end
            ST_MUL: begin
                if (more) begin
                    ram_re    = 1'b1;
                    ram_raddr = next_idx[ADDR_W-1:0];
                end
            end
            ST_RND: begin
                p_next   = rnd_sat;
                ovf_next = ovf_reg | rnd_ovf;
            end
            ST_ADD: begin
                acc_next       = sum_sat;
                res_value_next = sum_sat;
                if (more) begin
                    d_next    = diff_sat;
                    coef_next = rd_coef;
                    idx_next  = next_idx;
                    ovf_next  = ovf_reg | sum_ovf | diff_ovf;
                end else begin
                    ovf_next  = ovf_reg | sum_ovf;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_value_reg;
                    m_tcnt_next  = cnt_ext[TCNT_W-1:0];
                    m_ovf_next   = ovf_reg;
                    m_rej_next   = res_rej_reg;
                end
            end
            default: begin
                m_valid_next = m_valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        idx_reg       <= idx_next;
        x_reg         <= x_next;
        acc_reg       <= acc_next;
        d_reg         <= d_next;
        coef_reg      <= coef_next;
        prod_reg      <= prod_next;
        p_reg         <= p_next;
        ovf_reg       <= ovf_next;
        res_value_reg <= res_value_next;
        res_rej_reg   <= res_rej_next;
        m_value_reg   <= m_value_next;
        m_tcnt_reg    <= m_tcnt_next;
        m_ovf_reg     <= m_ovf_next;
        m_rej_reg     <= m_rej_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), m_tcnt_reg, m_value_reg};
    assign m_tuser  = {m_rej_reg, m_ovf_reg};

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_TERMS))
        else $error("term count above table depth");

    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && req == REQ_PUSH && cnt_reg == CNT_W'(MAX_TERMS))
        |=> ($stable(cnt_reg) && res_rej_reg))
        else $error("push to full table not refused");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL || state_reg == ST_RND || state_reg == ST_ADD)
        |-> (idx_reg < n_reg))
        else $error("term index beyond stored count");

    a_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("table read and write in the same cycle");

    a_empty_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && req == REQ_EVAL && cnt_reg == '0)
        |=> (state_reg == ST_FIN && res_value_reg == '0 && !ovf_reg))
        else $error("empty table eval not zero");

endmodule
